FILE: sv/cih_pkg.sv
package cih_pkg;

	localparam int INDEX_BITS   = 12;
	localparam int ENTRY_COUNT  = 1 << INDEX_BITS;
	localparam int FREE_W       = INDEX_BITS + 1;
	localparam int CMP_W        = (INDEX_BITS + 1 > 13) ? INDEX_BITS + 1 : 13;

	localparam int BUCKET_BITS  = 8;
	localparam int BUCKET_COUNT = 1 << BUCKET_BITS;
	localparam int HASH_SHIFT   = 64 - BUCKET_BITS;

	localparam logic [63:0] HASH_MULT = 64'h00FA_D3E3_95C4_12EB;
	localparam logic [31:0] HASH_LO   = HASH_MULT[31:0];
	localparam logic [31:0] HASH_HI   = HASH_MULT[63:32];

	// multiply steps of the hash sequencer
	localparam logic [1:0] HSTEP_LL = 2'd0;
	localparam logic [1:0] HSTEP_LH = 2'd1;
	localparam logic [1:0] HSTEP_HL = 2'd2;

	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_INTERN = 2'd2;

	typedef logic [INDEX_BITS-1:0]  entry_idx_t;
	typedef logic [FREE_W-1:0]      free_cnt_t;
	typedef logic [BUCKET_BITS-1:0] bucket_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] value;
		logic [11:0] index;
	} req_t;

	typedef struct packed {
		logic [11:0] result_index;
		logic [63:0] result_value;
		logic        found;
		logic        table_full;
	} rsp_t;

	typedef struct packed {
		entry_idx_t  link;
		logic [63:0] value;
	} ent_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_WALK,
		S_ALLOC,
		S_READ,
		S_RESP
	} state_t;

endpackage

FILE: sv/constant_intern_hash_table.sv
// Channel  Word               Handshake
// req      cih_pkg::req_t     req_valid / req_stall, accepted when valid and not stall
// rsp      cih_pkg::rsp_t     rsp_valid / rsp_stall, accepted when valid and not stall
//
// One word is in work at a time. A valid read passes S_READ and S_RESP on its way
// to the output register. Lookup and intern hash, read the bucket head and walk the
// chain (one entry memory read per cycle); an allocating intern adds S_ALLOC.
// The hash runs on a shared 32x32 multiplier.
// Reset empties all buckets through per-bucket valid bits; no clearing pass.
// A new word is taken while an earlier result still waits in the output register.
module constant_intern_hash_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cih_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cih_pkg::rsp_t   rsp
);

	cih_pkg::state_t    state_q, state_d;
	cih_pkg::free_cnt_t next_free_q;
	logic [cih_pkg::BUCKET_COUNT-1:0] head_vld_q;

	logic [1:0]          cmd_q;
	logic [63:0]         value_q;
	cih_pkg::entry_idx_t cur_q;
	cih_pkg::entry_idx_t head_q;
	cih_pkg::rsp_t       res_q;
	cih_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;

	cih_pkg::entry_idx_t head_mem [cih_pkg::BUCKET_COUNT];
	cih_pkg::entry_idx_t head_rd_q;
	cih_pkg::ent_word_t  ent_mem [cih_pkg::ENTRY_COUNT];
	cih_pkg::ent_word_t  ent_rd_q;

	logic                hash_start;
	logic                hash_done;
	cih_pkg::bucket_t    bucket;

	logic                accept;
	logic                rd_ok;
	logic                full;
	logic                hit;
	cih_pkg::entry_idx_t head_now;
	cih_pkg::entry_idx_t alloc_idx;

	logic                ent_re;
	cih_pkg::entry_idx_t ent_ra;
	logic                ent_we;
	logic                head_re;
	logic                head_we;
	logic                res_ld;
	cih_pkg::rsp_t       res_d;
	logic                rsp_ld;
	logic                miss_alloc;
	cih_pkg::rsp_t       miss_res;

	cih_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.value  (value_q),
		.done   (hash_done),
		.bucket (bucket)
	);

	assign req_stall = (state_q != cih_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign alloc_idx = next_free_q[cih_pkg::INDEX_BITS-1:0];
	assign full      = (next_free_q == cih_pkg::FREE_W'(cih_pkg::ENTRY_COUNT));
	assign hit       = (ent_rd_q.value == value_q);
	assign head_now  = head_vld_q[bucket] ? head_rd_q : '0;
	assign rd_ok     = (req.index != '0)
		&& (cih_pkg::CMP_W'(req.index) < cih_pkg::CMP_W'(next_free_q))
		&& (cih_pkg::CMP_W'(req.index) < cih_pkg::CMP_W'(cih_pkg::ENTRY_COUNT));

	// end of a chain with no match
	always_comb begin
		miss_res   = '0;
		miss_alloc = 1'b0;
		if (cmd_q == cih_pkg::CMD_INTERN) begin
			if (full) begin
				miss_res.table_full = 1'b1;
			end else begin
				miss_alloc = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cih_pkg::S_IDLE: begin
				if (accept) begin
					if (req.command == cih_pkg::CMD_READ) begin
						state_d = rd_ok ? cih_pkg::S_READ : cih_pkg::S_RESP;
					end else if (req.command == cih_pkg::CMD_LOOKUP
							|| req.command == cih_pkg::CMD_INTERN) begin
						state_d = cih_pkg::S_HASH;
					end else begin
						state_d = cih_pkg::S_RESP;
					end
				end
			end
			cih_pkg::S_HASH: begin
				if (hash_done) begin
					state_d = cih_pkg::S_HEAD;
				end
			end
			cih_pkg::S_HEAD: begin
				if (head_now != '0) begin
					state_d = cih_pkg::S_WALK;
				end else begin
					state_d = miss_alloc ? cih_pkg::S_ALLOC : cih_pkg::S_RESP;
				end
			end
			cih_pkg::S_WALK: begin
				if (hit) begin
					state_d = cih_pkg::S_RESP;
				end else if (ent_rd_q.link == '0) begin
					state_d = miss_alloc ? cih_pkg::S_ALLOC : cih_pkg::S_RESP;
				end
			end
			cih_pkg::S_ALLOC: state_d = cih_pkg::S_RESP;
			cih_pkg::S_READ:  state_d = cih_pkg::S_RESP;
			cih_pkg::S_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = cih_pkg::S_IDLE;
				end
			end
			default: state_d = cih_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ent_re     = 1'b0;
		ent_ra     = '0;
		ent_we     = 1'b0;
		head_re    = 1'b0;
		head_we    = 1'b0;
		hash_start = 1'b0;
		res_ld     = 1'b0;
		res_d      = '0;
		rsp_ld     = 1'b0;
		unique case (state_q)
			cih_pkg::S_IDLE: begin
				if (accept) begin
					if (req.command == cih_pkg::CMD_READ) begin
						ent_re = rd_ok;
						ent_ra = cih_pkg::entry_idx_t'(req.index);
						res_ld = !rd_ok;
					end else if (req.command == cih_pkg::CMD_LOOKUP
							|| req.command == cih_pkg::CMD_INTERN) begin
						hash_start = 1'b1;
					end else begin
						res_ld = 1'b1;
					end
				end
			end
			cih_pkg::S_HASH: begin
				head_re = hash_done;
			end
			cih_pkg::S_HEAD: begin
				if (head_now != '0) begin
					ent_re = 1'b1;
					ent_ra = head_now;
				end else begin
					res_ld = !miss_alloc;
					res_d  = miss_res;
				end
			end
			cih_pkg::S_WALK: begin
				if (hit) begin
					res_ld             = 1'b1;
					res_d.result_index = 12'(cur_q);
					res_d.found        = 1'b1;
				end else if (ent_rd_q.link != '0) begin
					ent_re = 1'b1;
					ent_ra = ent_rd_q.link;
				end else begin
					res_ld = !miss_alloc;
					res_d  = miss_res;
				end
			end
			cih_pkg::S_ALLOC: begin
				ent_we             = 1'b1;
				head_we            = 1'b1;
				res_ld             = 1'b1;
				res_d.result_index = 12'(alloc_idx);
			end
			cih_pkg::S_READ: begin
				res_ld             = 1'b1;
				res_d.result_value = ent_rd_q.value;
				res_d.found        = 1'b1;
			end
			cih_pkg::S_RESP: begin
				rsp_ld = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				res_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cih_pkg::S_IDLE;
			next_free_q <= cih_pkg::free_cnt_t'(1);
			head_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_we) begin
				next_free_q        <= next_free_q + cih_pkg::free_cnt_t'(1);
				head_vld_q[bucket] <= 1'b1;
			end
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			value_q <= req.value;
		end
		if (state_q == cih_pkg::S_HEAD) begin
			head_q <= head_now;
			cur_q  <= head_now;
		end else if (ent_re && state_q == cih_pkg::S_WALK) begin
			cur_q <= ent_rd_q.link;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (rsp_ld) begin
			rsp_q <= res_q;
		end
	end

	// link the new entry ahead of the old bucket head
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[bucket] <= alloc_idx;
		end
		if (head_re) begin
			head_rd_q <= head_mem[bucket];
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[alloc_idx] <= '{link: head_q, value: value_q};
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_ra];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q != '0
		&& next_free_q <= cih_pkg::FREE_W'(cih_pkg::ENTRY_COUNT))
		else $error("next free index out of range");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cih_pkg::S_ALLOC |=>
		next_free_q == $past(next_free_q) + cih_pkg::free_cnt_t'(1))
		else $error("allocation did not advance next free index");

	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cih_pkg::S_WALK |-> cur_q != '0)
		else $error("chain walk on null entry");

	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.found && rsp.table_full))
		else $error("result both found and full");
`endif

endmodule

FILE: sv/cih_hash.sv
module cih_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         value,
	output logic                done,
	output cih_pkg::bucket_t    bucket
);

	logic        busy_q;
	logic        done_q;
	logic [1:0]  step_q;
	logic [63:0] acc_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// low 64 bits of value * mult = ll + ((lh + hl) << 32)
	always_comb begin
		op_a = (step_q == cih_pkg::HSTEP_HL) ? value[63:32] : value[31:0];
		op_b = (step_q == cih_pkg::HSTEP_LH) ? cih_pkg::HASH_HI : cih_pkg::HASH_LO;
		prod = 64'(op_a) * 64'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= cih_pkg::HSTEP_LL;
		end else begin
			done_q <= busy_q && (step_q == cih_pkg::HSTEP_HL);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= cih_pkg::HSTEP_LL;
			end else if (busy_q) begin
				if (step_q == cih_pkg::HSTEP_HL) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (step_q == cih_pkg::HSTEP_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

	assign done   = done_q;
	assign bucket = acc_q[63:cih_pkg::HASH_SHIFT];

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HOT_BUCKETS = 8;
	localparam int DRAIN_LIMIT = 200000;
	localparam int REPORT_CAP  = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	cih_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cih_pkg::rsp_t rsp;

	constant_intern_hash_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the intern table
	logic [11:0] tbl_head [cih_pkg::BUCKET_COUNT];
	logic [63:0] tbl_val  [cih_pkg::ENTRY_COUNT];
	logic [11:0] tbl_link [cih_pkg::ENTRY_COUNT];
	logic [12:0] tbl_next;

	cih_pkg::rsp_t pending_rsp [$];

	int n_errors = 0;
	int n_words = 0;
	int n_alloc = 0;
	int n_hits = 0;
	int n_full = 0;
	int n_reads = 0;
	int n_read_hits = 0;
	int n_unused = 0;

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_hold = 0;
	bit rx_holding = 1'b0;

	function automatic void table_clear();
		for (int i = 0; i < cih_pkg::BUCKET_COUNT; i++)
			tbl_head[cih_pkg::bucket_t'(i)] = '0;
		for (int i = 0; i < cih_pkg::ENTRY_COUNT; i++) begin
			tbl_val[cih_pkg::entry_idx_t'(i)] = '0;
			tbl_link[cih_pkg::entry_idx_t'(i)] = '0;
		end
		tbl_next = 13'd1;
	endfunction

	function automatic cih_pkg::bucket_t hash_bucket(input logic [63:0] v);
		logic [63:0] prod;
		prod = v * cih_pkg::HASH_MULT;
		return prod[63 -: cih_pkg::BUCKET_BITS];
	endfunction

	function automatic logic [11:0] chain_find(input logic [63:0] v);
		logic [11:0] cur;
		int steps;
		cur = tbl_head[hash_bucket(v)];
		steps = 0;
		while (cur != '0 && steps < cih_pkg::ENTRY_COUNT) begin
			if (tbl_val[cur] == v) return cur;
			cur = tbl_link[cur];
			steps++;
		end
		return '0;
	endfunction

	// apply one word to the shadow table and return the result it produces
	function automatic cih_pkg::rsp_t table_apply(input cih_pkg::req_t w);
		cih_pkg::rsp_t r;
		logic [11:0] hit;
		cih_pkg::bucket_t b;
		r = '0;
		case (w.command)
			cih_pkg::CMD_READ: begin
				if (w.index != '0 && w.index < tbl_next) begin
					r.result_value = tbl_val[w.index];
					r.found = 1'b1;
				end
			end
			cih_pkg::CMD_LOOKUP, cih_pkg::CMD_INTERN: begin
				b = hash_bucket(w.value);
				hit = chain_find(w.value);
				if (hit != '0) begin
					r.result_index = hit;
					r.found = 1'b1;
				end else if (w.command == cih_pkg::CMD_INTERN) begin
					if (tbl_next >= cih_pkg::ENTRY_COUNT) begin
						r.table_full = 1'b1;
					end else begin
						tbl_val[tbl_next[11:0]] = w.value;
						tbl_link[tbl_next[11:0]] = tbl_head[b];
						tbl_head[b] = tbl_next[11:0];
						r.result_index = tbl_next[11:0];
						tbl_next = tbl_next + 13'd1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cih_pkg::req_t mk_word(input logic [1:0] cmd, input logic [63:0] v,
			input logic [11:0] idx);
		cih_pkg::req_t w;
		w.command = cmd;
		w.value = v;
		w.index = idx;
		return w;
	endfunction

	function automatic logic [63:0] fresh_value();
		logic [63:0] v;
		int k;
		k = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		if (k < 3) begin
			// crowd a few buckets so chains get long
			while (hash_bucket(v) >= HOT_BUCKETS) v = {$urandom, $urandom};
		end else if (k == 3) begin
			v = 64'($urandom_range(0, 15));
		end else if (k == 4) begin
			v = ~64'($urandom_range(0, 15));
		end else if (k == 5) begin
			v = 64'd1 << $urandom_range(0, 63);
		end
		return v;
	endfunction

	function automatic logic [63:0] stored_value();
		if (tbl_next <= 13'd1) return fresh_value();
		return tbl_val[cih_pkg::entry_idx_t'($urandom_range(1, int'(tbl_next) - 1))];
	endfunction

	function automatic logic [63:0] same_bucket_value(input logic [63:0] v);
		logic [63:0] c;
		c = {$urandom, $urandom};
		while (hash_bucket(c) != hash_bucket(v) || c == v) c = {$urandom, $urandom};
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		n_errors++;
		if (n_errors <= REPORT_CAP)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// send one word; valid stays high on return, so the caller sends again or drops it
	task automatic send_word(input cih_pkg::req_t w);
		cih_pkg::rsp_t r;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		r = table_apply(w);
		pending_rsp.push_back(r);
		n_words++;
		case (w.command)
			cih_pkg::CMD_READ: begin
				n_reads++;
				if (r.found) n_read_hits++;
			end
			cih_pkg::CMD_LOOKUP, cih_pkg::CMD_INTERN: begin
				if (r.found) n_hits++;
				else if (r.table_full) n_full++;
				else if (w.command == cih_pkg::CMD_INTERN) n_alloc++;
			end
			default: n_unused++;
		endcase
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	initial begin : rx_stall_gen
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				rsp_stall <= 1'b1;
				rx_holding = 1'b1;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
				rx_holding = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat (rx_idle_en ? $urandom_range(1, 17) : 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		cih_pkg::rsp_t want;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result word with none pending", 64'(rsp.result_index), '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.result_index !== want.result_index)
					report_mismatch("result_index", 64'(rsp.result_index),
						64'(want.result_index));
				if (rsp.result_value !== want.result_value)
					report_mismatch("result_value", rsp.result_value, want.result_value);
				if (rsp.found !== want.found)
					report_mismatch("found", 64'(rsp.found), 64'(want.found));
				if (rsp.table_full !== want.table_full)
					report_mismatch("table_full", 64'(rsp.table_full), 64'(want.table_full));
			end
		end
	end

	task automatic test_directed();
		logic [63:0] va;
		logic [63:0] vb;
		logic [63:0] vc;
		logic [63:0] vd;
		va = {$urandom, $urandom};
		vb = same_bucket_value(va);
		vc = same_bucket_value(va);
		vd = same_bucket_value(va);
		// empty table: reads and lookups all miss
		send_word(mk_word(cih_pkg::CMD_READ, '1, 12'd0));
		send_word(mk_word(cih_pkg::CMD_READ, '0, 12'd1));
		send_word(mk_word(cih_pkg::CMD_READ, '0, '1));
		send_word(mk_word(cih_pkg::CMD_LOOKUP, '0, '1));
		send_word(mk_word(cih_pkg::CMD_LOOKUP, '1, '0));
		// extremes of the value field
		send_word(mk_word(cih_pkg::CMD_INTERN, '0, '0));
		send_word(mk_word(cih_pkg::CMD_INTERN, '1, '1));
		send_word(mk_word(cih_pkg::CMD_INTERN, '0, '1));
		send_word(mk_word(cih_pkg::CMD_LOOKUP, '0, '0));
		send_word(mk_word(cih_pkg::CMD_LOOKUP, '1, '0));
		send_word(mk_word(cih_pkg::CMD_READ, '1, 12'd1));
		send_word(mk_word(cih_pkg::CMD_READ, '0, 12'd2));
		send_word(mk_word(cih_pkg::CMD_READ, '0, 12'd3));
		send_word(mk_word(CMD_UNUSED, '1, '1));
		// one chain of three, searched to its tail
		send_word(mk_word(cih_pkg::CMD_INTERN, va, '0));
		send_word(mk_word(cih_pkg::CMD_INTERN, vb, '0));
		send_word(mk_word(cih_pkg::CMD_INTERN, vc, '0));
		send_word(mk_word(cih_pkg::CMD_LOOKUP, va, '0));
		send_word(mk_word(cih_pkg::CMD_LOOKUP, vd, '0));
		send_word(mk_word(cih_pkg::CMD_INTERN, vb, '0));
		send_word(mk_word(cih_pkg::CMD_READ, '0, 12'(tbl_next - 13'd1)));
		send_word(mk_word(cih_pkg::CMD_READ, '0, 12'(tbl_next)));
		send_word(mk_word(CMD_UNUSED, '0, '0));
	endtask

	task automatic test_random(input int count);
		cih_pkg::req_t w;
		int k;
		repeat (count) begin
			k = $urandom_range(0, 99);
			if (k < 22)
				w = mk_word(cih_pkg::CMD_INTERN, fresh_value(), 12'($urandom));
			else if (k < 35)
				w = mk_word(cih_pkg::CMD_INTERN, stored_value(), 12'($urandom));
			else if (k < 48)
				w = mk_word(cih_pkg::CMD_LOOKUP, stored_value(), 12'($urandom));
			else if (k < 60)
				w = mk_word(cih_pkg::CMD_LOOKUP, fresh_value(), 12'($urandom));
			else if (k < 80)
				w = mk_word(cih_pkg::CMD_READ, {$urandom, $urandom},
					12'($urandom_range(0, int'(tbl_next) + 1)));
			else if (k < 88)
				w = mk_word(cih_pkg::CMD_READ, {$urandom, $urandom}, 12'($urandom));
			else if (k < 93)
				w = mk_word(CMD_UNUSED, {$urandom, $urandom}, 12'($urandom));
			else
				w = mk_word(2'($urandom), {$urandom, $urandom}, 12'($urandom));
			send_word(w);
		end
	endtask

	// hold the output side long enough that the block backs up into its input
	task automatic test_output_hold();
		req_valid <= 1'b0;
		tx_idle_en = 1'b0;
		rx_hold = 300;
		while (!rx_holding) @(posedge clk);
		repeat (16) begin
			if ($urandom_range(0, 1) == 0)
				send_word(mk_word(cih_pkg::CMD_INTERN, fresh_value(), 12'($urandom)));
			else
				send_word(mk_word(cih_pkg::CMD_LOOKUP, stored_value(), 12'($urandom)));
		end
		tx_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause();
		wait_drained();
		repeat (40) @(posedge clk);
	endtask

	// from here on neither side idles
	task automatic test_steady(input int count);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random(count);
	endtask

	task automatic finish_run();
		int guard;
		req_valid <= 1'b0;
		guard = 0;
		while (pending_rsp.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch("result words never returned", 64'(pending_rsp.size()), '0);
		$display("covered %0d words: %0d new entries, %0d hits, %0d rejected as full",
			n_words, n_alloc, n_hits, n_full);
		$display("reads %0d (%0d of allocated entries), %0d with unused command, %0d errors",
			n_reads, n_read_hits, n_unused, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	endtask

	initial begin
		table_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(800);
		test_output_hold();
		test_random(500);
		test_drain_pause();
		test_steady(300);
		finish_run();
	end

	initial begin : watchdog
		#100000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
sv/cih_pkg.sv
sv/cih_hash.sv
sv/constant_intern_hash_table.sv
tb/sv/tb_top.sv
